// ===== hdl/bdfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond damage evaluator package
// Shared widths, constants, mode codes, controller states and the command
// group that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package bdfe_pkg;

  localparam int STRAIN_W  = 32;
  localparam int DAMAGE_FB = 16;
  localparam int DAMAGE_W  = DAMAGE_FB + 1;
  localparam int COUNT_W   = 17;
  localparam int ITER_W    = $clog2(DAMAGE_FB);

  localparam logic [STRAIN_W-1:0] STRAIN_INF = {STRAIN_W{1'b1}};
  localparam logic [DAMAGE_W-1:0] DAMAGE_ONE = {1'b1, {DAMAGE_FB{1'b0}}};
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [ITER_W-1:0]   ITER_LAST  = ITER_W'(DAMAGE_FB - 1);

  typedef enum logic [1:0] {
    MODE_TENSION     = 2'd0,
    MODE_COMPRESSION = 2'd1,
    MODE_SHEAR       = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic setup;
    logic iterate;
    logic load;
  } dp_cmd_t;

endpackage

// ===== hdl/bdfe_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond damage evaluator ramp lane
// Holds one mode's peak and thresholds and forms its clamped damage ramp
// with a radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bdfe_lane (
  input  logic                          clk,
  input  bdfe_pkg::dp_cmd_t             cmd,
  input  logic [bdfe_pkg::STRAIN_W-1:0] peak_in,
  input  logic [bdfe_pkg::STRAIN_W-1:0] start_in,
  input  logic [bdfe_pkg::STRAIN_W-1:0] end_in,
  output logic [bdfe_pkg::STRAIN_W-1:0] peak,
  output logic [bdfe_pkg::DAMAGE_W-1:0] ramp
);
  import bdfe_pkg::*;

  logic [STRAIN_W-1:0]  start_r;
  logic [STRAIN_W-1:0]  end_r;
  logic [STRAIN_W-1:0]  rem;
  logic [STRAIN_W-1:0]  dvs;
  logic [DAMAGE_FB-1:0] quo;
  logic                 is_zero;
  logic                 is_one;

  logic [STRAIN_W-1:0]  diff_v;
  logic [STRAIN_W-1:0]  diff_e;
  logic [STRAIN_W:0]    shifted;
  logic [STRAIN_W:0]    trial;
  logic                 fits;

  assign diff_v  = peak - start_r;
  assign diff_e  = end_r - start_r;
  assign shifted = {rem, 1'b0};
  assign trial   = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      peak    <= peak_in;
      start_r <= start_in;
      end_r   <= end_in;
    end
    if (cmd.setup) begin
      is_zero <= (start_r == STRAIN_INF) || (peak <= start_r);
      is_one  <= (end_r == STRAIN_INF) || (end_r <= start_r) || (diff_v >= diff_e);
      rem     <= diff_v;
      dvs     <= diff_e;
      quo     <= '0;
    end else if (cmd.iterate) begin
      if (fits) begin
        rem <= trial[STRAIN_W-1:0];
        quo <= {quo[DAMAGE_FB-2:0], 1'b1};
      end else begin
        rem <= shifted[STRAIN_W-1:0];
        quo <= {quo[DAMAGE_FB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (is_zero) begin
      ramp = '0;
    end else if (is_one) begin
      ramp = DAMAGE_ONE;
    end else begin
      ramp = {1'b0, quo};
    end
  end

endmodule

// ===== hdl/bdfe_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond damage evaluator datapath
// Three ramp lanes, the mode selection, the damage update and the pass
// state: running peak maxima and the saturating broken-bond count.
// ----------------------------------------------------------------------------
module bdfe_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bdfe_pkg::dp_cmd_t             cmd,
  input  logic                          start_of_pass,
  input  logic                          alive,
  input  logic [bdfe_pkg::STRAIN_W-1:0] peak_tensile,
  input  logic [bdfe_pkg::STRAIN_W-1:0] peak_compressive,
  input  logic [bdfe_pkg::STRAIN_W-1:0] peak_shear,
  input  logic [bdfe_pkg::STRAIN_W-1:0] tensile_start,
  input  logic [bdfe_pkg::STRAIN_W-1:0] tensile_end,
  input  logic [bdfe_pkg::STRAIN_W-1:0] compressive_start,
  input  logic [bdfe_pkg::STRAIN_W-1:0] compressive_end,
  input  logic [bdfe_pkg::STRAIN_W-1:0] shear_start,
  input  logic [bdfe_pkg::STRAIN_W-1:0] shear_end,
  input  logic [bdfe_pkg::DAMAGE_W-1:0] prior_damage,
  output logic [bdfe_pkg::DAMAGE_W-1:0] new_damage,
  output logic [1:0]                    winning_mode,
  output logic                          damage_raised,
  output logic                          broken_now,
  output logic [bdfe_pkg::STRAIN_W-1:0] running_max_tensile,
  output logic [bdfe_pkg::STRAIN_W-1:0] running_max_compressive,
  output logic [bdfe_pkg::STRAIN_W-1:0] running_max_shear,
  output logic [bdfe_pkg::COUNT_W-1:0]  broken_total
);
  import bdfe_pkg::*;

  logic                sop_r;
  logic                alive_r;
  logic [DAMAGE_W-1:0] prior_r;

  logic [STRAIN_W-1:0] pk_t, pk_c, pk_s;
  logic [DAMAGE_W-1:0] ramp_t, ramp_c, ramp_s;

  logic [DAMAGE_W-1:0] prior_clamped;
  logic [DAMAGE_W-1:0] best;
  mode_t               best_mode;
  logic                raised;
  logic [DAMAGE_W-1:0] dmg;
  logic                broken;
  logic [STRAIN_W-1:0] base_t, base_c, base_s;
  logic [COUNT_W-1:0]  base_cnt;

  bdfe_lane u_lane_t (
    .clk(clk), .cmd(cmd), .peak_in(peak_tensile), .start_in(tensile_start),
    .end_in(tensile_end), .peak(pk_t), .ramp(ramp_t)
  );

  bdfe_lane u_lane_c (
    .clk(clk), .cmd(cmd), .peak_in(peak_compressive), .start_in(compressive_start),
    .end_in(compressive_end), .peak(pk_c), .ramp(ramp_c)
  );

  bdfe_lane u_lane_s (
    .clk(clk), .cmd(cmd), .peak_in(peak_shear), .start_in(shear_start),
    .end_in(shear_end), .peak(pk_s), .ramp(ramp_s)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sop_r   <= start_of_pass;
      alive_r <= alive;
      prior_r <= prior_damage;
    end
  end

  always_comb begin
    prior_clamped = (prior_r > DAMAGE_ONE) ? DAMAGE_ONE : prior_r;
    best      = ramp_t;
    best_mode = MODE_TENSION;
    if (ramp_c > best) begin
      best      = ramp_c;
      best_mode = MODE_COMPRESSION;
    end
    if (ramp_s > best) begin
      best      = ramp_s;
      best_mode = MODE_SHEAR;
    end
    raised   = alive_r && (best > prior_clamped);
    dmg      = raised ? best : prior_clamped;
    broken   = alive_r && (dmg >= DAMAGE_ONE);
    base_t   = sop_r ? '0 : running_max_tensile;
    base_c   = sop_r ? '0 : running_max_compressive;
    base_s   = sop_r ? '0 : running_max_shear;
    base_cnt = sop_r ? '0 : broken_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max_tensile     <= '0;
      running_max_compressive <= '0;
      running_max_shear       <= '0;
      broken_total            <= '0;
    end else if (cmd.load) begin
      running_max_tensile     <= (alive_r && (pk_t > base_t)) ? pk_t : base_t;
      running_max_compressive <= (alive_r && (pk_c > base_c)) ? pk_c : base_c;
      running_max_shear       <= (alive_r && (pk_s > base_s)) ? pk_s : base_s;
      broken_total            <= (broken && (base_cnt != COUNT_MAX)) ?
                                 base_cnt + COUNT_W'(1) : base_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_damage    <= dmg;
      winning_mode  <= raised ? best_mode : MODE_TENSION;
      damage_raised <= raised;
      broken_now    <= broken;
    end
  end

endmodule

// ===== hdl/bdfe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond damage evaluator controller
// Sequences capture, divider setup, the quotient-bit loop and the result
// load, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module bdfe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bdfe_pkg::dp_cmd_t cmd
);
  import bdfe_pkg::*;

  ctrl_state_t       state;
  ctrl_state_t       state_next;
  logic [ITER_W-1:0] iter_cnt;
  logic              slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.setup) begin
        iter_cnt <= '0;
      end else if (cmd.iterate) begin
        iter_cnt <= iter_cnt + ITER_W'(1);
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (iter_cnt == ITER_LAST) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = !rst;
        cmd.capture = in_valid;
      end
      ST_SETUP:  cmd.setup   = 1'b1;
      ST_DIVIDE: cmd.iterate = 1'b1;
      ST_DONE:   cmd.load    = slot_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/bond_damage_failure_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond damage and failure evaluator
// Per bond, forms tension, compression and shear damage ramps, keeps the
// largest, raises the stored damage and flags breakage, while tracking the
// peak maxima and broken-bond count of the current pass.
//
//   Channel | Handshake            | Payload
//   input   | in_valid / in_ready  | start_of_pass, alive, peaks, thresholds,
//           |                      | prior_damage
//   output  | out_valid / out_ready| new_damage, winning_mode, damage_raised,
//           |                      | broken_now, running maxima, broken_total
//
// Each bond passes capture, divider setup, the radix-2 quotient loop of the
// ramp lanes and the result load; the next bond is taken only after the load.
// A finished result waits in the output register while the next bond is taken.
// If the output is stalled, the block holds its finished bond until the
// register is free. Reset clears the pass maxima and count and empties the
// output register.
// ----------------------------------------------------------------------------
module bond_damage_failure_evaluator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          start_of_pass,
  input  logic                          alive,
  input  logic [bdfe_pkg::STRAIN_W-1:0] peak_tensile,
  input  logic [bdfe_pkg::STRAIN_W-1:0] peak_compressive,
  input  logic [bdfe_pkg::STRAIN_W-1:0] peak_shear,
  input  logic [bdfe_pkg::STRAIN_W-1:0] tensile_start,
  input  logic [bdfe_pkg::STRAIN_W-1:0] tensile_end,
  input  logic [bdfe_pkg::STRAIN_W-1:0] compressive_start,
  input  logic [bdfe_pkg::STRAIN_W-1:0] compressive_end,
  input  logic [bdfe_pkg::STRAIN_W-1:0] shear_start,
  input  logic [bdfe_pkg::STRAIN_W-1:0] shear_end,
  input  logic [bdfe_pkg::DAMAGE_W-1:0] prior_damage,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bdfe_pkg::DAMAGE_W-1:0] new_damage,
  output logic [1:0]                    winning_mode,
  output logic                          damage_raised,
  output logic                          broken_now,
  output logic [bdfe_pkg::STRAIN_W-1:0] running_max_tensile,
  output logic [bdfe_pkg::STRAIN_W-1:0] running_max_compressive,
  output logic [bdfe_pkg::STRAIN_W-1:0] running_max_shear,
  output logic [bdfe_pkg::COUNT_W-1:0]  broken_total
);
  import bdfe_pkg::*;

  dp_cmd_t cmd;

  bdfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bdfe_dp u_dp (
    .clk                     (clk),
    .rst                     (rst),
    .cmd                     (cmd),
    .start_of_pass           (start_of_pass),
    .alive                   (alive),
    .peak_tensile            (peak_tensile),
    .peak_compressive        (peak_compressive),
    .peak_shear              (peak_shear),
    .tensile_start           (tensile_start),
    .tensile_end             (tensile_end),
    .compressive_start       (compressive_start),
    .compressive_end         (compressive_end),
    .shear_start             (shear_start),
    .shear_end               (shear_end),
    .prior_damage            (prior_damage),
    .new_damage              (new_damage),
    .winning_mode            (winning_mode),
    .damage_raised           (damage_raised),
    .broken_now              (broken_now),
    .running_max_tensile     (running_max_tensile),
    .running_max_compressive (running_max_compressive),
    .running_max_shear       (running_max_shear),
    .broken_total            (broken_total)
  );

endmodule

// ===== hdl/bdfe_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bond damage evaluator checker
// Watches the top-level ports for breakage, mode and handshake consistency.
// ----------------------------------------------------------------------------
module bdfe_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bdfe_pkg::DAMAGE_W-1:0] new_damage,
  input logic [1:0]                    winning_mode,
  input logic                          damage_raised,
  input logic                          broken_now,
  input logic [bdfe_pkg::COUNT_W-1:0]  broken_total
);
  import bdfe_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken on consecutive cycles.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_damage) && $stable(broken_total))
    else $error("Stalled result changed or was dropped.");

  a_broken_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && broken_now |-> new_damage == DAMAGE_ONE && broken_total != '0)
    else $error("Broken bond without full damage or count.");

  a_mode_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !damage_raised |-> winning_mode == MODE_TENSION)
    else $error("Mode shown without a damage rise.");

endmodule

bind bond_damage_failure_evaluator bdfe_chk u_bdfe_chk (.*);
